// ----- hdl/wsd_pkg.sv -----
`default_nettype none
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_LEN   = 3'd1,
        PH_EXT   = 3'd2,
        PH_MASK  = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [7:0] OP_TEXT   = 8'h81;
    localparam logic [7:0] OP_BINARY = 8'h82;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] HEAD_SHORT = 4'd6;
    localparam logic [3:0] HEAD_MID   = 4'd8;
    localparam logic [3:0] HEAD_LONG  = 4'd14;
    localparam logic [3:0] KEY_BYTES  = 4'd4;

    localparam int QUEUE_DEPTH = 2;

    // one classified byte handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] key;
        logic [1:0]  lane;
        logic        text;
        logic [3:0]  head;
        logic [31:0] length;
        logic        last;
    } cmd_t;

endpackage
`default_nettype wire

// ----- hdl/wsd_byte_if.sv -----
`default_nettype none
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/wsd_result_if.sv -----
`default_nettype none
interface wsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_out;
    logic        text_frame;
    logic [3:0]  head_bytes;
    logic [31:0] frame_length;
    logic        frame_last;

    modport source (output valid, output kind, output payload_out, output text_frame,
                    output head_bytes, output frame_length, output frame_last,
                    input ready);
    modport sink   (input valid, input kind, input payload_out, input text_frame,
                    input head_bytes, input frame_length, input frame_last,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/wsd_front.sv -----
`default_nettype none
module wsd_front #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    wsd_byte_if.sink           in_ch,
    input  wire logic          space,
    output logic               push,
    output wsd_pkg::cmd_t      cmd
);
    import wsd_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [3:0]               count_reg, count_next;
    logic [6:0]               code_reg, code_next;
    logic [LENGTH_BITS-1:0]   accum_reg, accum_next;
    logic [31:0]              key_reg, key_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic [1:0]               lane_reg, lane_next;
    logic                     text_reg, text_next;

    logic                     accept;
    logic [7:0]               b;
    logic [3:0]               head;
    logic [3:0]               count_inc;
    logic [LENGTH_BITS-1:0]   left_dec;
    logic [63:0]              accum_wide;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;
    assign b           = in_ch.rx_byte;
    assign count_inc   = count_reg + 4'd1;
    assign left_dec    = left_reg - LENGTH_BITS'(1);
    assign accum_wide  = 64'(accum_reg);

    always_comb
    begin
        if (code_reg == LEN_CODE_16)
            head = HEAD_MID;
        else if (code_reg == LEN_CODE_64)
            head = HEAD_LONG;
        else
            head = HEAD_SHORT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            count_reg <= '0;
            code_reg  <= '0;
            accum_reg <= '0;
            key_reg   <= '0;
            left_reg  <= '0;
            lane_reg  <= '0;
            text_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            code_reg  <= code_next;
            accum_reg <= accum_next;
            key_reg   <= key_next;
            left_reg  <= left_next;
            lane_reg  <= lane_next;
            text_reg  <= text_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        code_next  = code_reg;
        accum_next = accum_reg;
        key_next   = key_reg;
        left_next  = left_reg;
        lane_next  = lane_reg;
        text_next  = text_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.kind   = KIND_HEADER;

        unique case (phase_reg)
            PH_LEN:
            begin
                code_next  = b[6:0];
                count_next = 4'd2;
                key_next   = '0;
                if (b[6:0] >= LEN_CODE_16)
                begin
                    accum_next = '0;
                    phase_next = PH_EXT;
                end
                else
                begin
                    accum_next = LENGTH_BITS'(b[6:0]);
                    phase_next = PH_MASK;
                end
            end
            PH_EXT:
            begin
                accum_next = {accum_reg[LENGTH_BITS-9:0], b};
                count_next = count_inc;
                if (count_inc >= head - KEY_BYTES)
                    phase_next = PH_MASK;
            end
            PH_MASK:
            begin
                key_next   = {key_reg[23:0], b};
                count_next = count_inc;
                if (count_inc >= head)
                begin
                    push       = accept;
                    cmd.kind   = KIND_HEADER;
                    cmd.text   = text_reg;
                    cmd.head   = head;
                    cmd.length = accum_wide[31:0];
                    cmd.last   = (accum_reg == '0);
                    left_next  = accum_reg;
                    lane_next  = '0;
                    count_next = '0;
                    phase_next = (accum_reg == '0) ? PH_FIRST : PH_DATA;
                end
            end
            PH_DATA:
            begin
                push       = accept;
                cmd.kind   = KIND_DATA;
                cmd.data   = b;
                cmd.key    = key_reg;
                cmd.lane   = lane_reg;
                cmd.text   = text_reg;
                cmd.last   = (left_dec == '0);
                left_next  = left_dec;
                lane_next  = lane_reg + 2'd1;
                if (left_dec == '0)
                    phase_next = PH_FIRST;
            end
            default:
            begin
                count_next = '0;
                if (b == OP_TEXT || b == OP_BINARY)
                begin
                    text_next  = (b == OP_TEXT);
                    count_next = 4'd1;
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_FIRST;
                    push       = accept;
                    cmd.kind   = KIND_ERROR;
                    cmd.last   = 1'b1;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/wsd_queue.sv -----
`default_nettype none
module wsd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wsd_pkg::cmd_t      push_cmd,
    output logic               space,
    input  wire logic          pop,
    output logic               head_valid,
    output wsd_pkg::cmd_t      head_cmd
);
    import wsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign space      = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a transfer");

endmodule
`default_nettype wire

// ----- hdl/wsd_back.sv -----
`default_nettype none
module wsd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wsd_pkg::cmd_t      head_cmd,
    output logic               pop,
    wsd_result_if.source       out_ch
);
    import wsd_pkg::*;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  payload_reg;
    logic        text_reg;
    logic [3:0]  head_reg;
    logic [31:0] length_reg;
    logic        last_reg;

    logic [7:0]  key_byte;
    logic [7:0]  payload_next;

    always_comb
    begin
        case (head_cmd.lane)
            2'd0:    key_byte = head_cmd.key[31:24];
            2'd1:    key_byte = head_cmd.key[23:16];
            2'd2:    key_byte = head_cmd.key[15:8];
            default: key_byte = head_cmd.key[7:0];
        endcase
        payload_next = (head_cmd.kind == KIND_DATA) ? (head_cmd.data ^ key_byte) : 8'h00;
    end

    assign pop = head_valid && (!valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ch.ready)
            valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= head_cmd.kind;
            payload_reg <= payload_next;
            text_reg    <= head_cmd.text;
            head_reg    <= head_cmd.head;
            length_reg  <= head_cmd.length;
            last_reg    <= head_cmd.last;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.kind         = kind_reg;
    assign out_ch.payload_out  = payload_reg;
    assign out_ch.text_frame   = text_reg;
    assign out_ch.head_bytes   = head_reg;
    assign out_ch.frame_length = length_reg;
    assign out_ch.frame_last   = last_reg;

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_ERROR) |->
            (last_reg && payload_reg == 8'h00 && head_reg == 4'd0 && !text_reg))
        else $error("error transfer carries stray fields");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_DATA) |->
            (head_reg == 4'd0 && length_reg == 32'd0))
        else $error("payload transfer carries header fields");

endmodule
`default_nettype wire

// ----- hdl/websocket_frame_deframer_top.sv -----
`default_nettype none
// Deframes a received byte stream: header parse, mask key capture, payload unmask.
// A result is held first in a queue entry, written when the byte that causes it is transferred,
// then in the output register, loaded from the queue head when the output register is free.
// Throughput: one byte per cycle; a stalled output fills the two-entry queue, then in.ready drops.
// Reset (rst_n, async, active low): parser waits for a first byte, queue and output empty.
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wsd_byte_if.sink        in_ch,
    wsd_result_if.source    out_ch
);
    import wsd_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  space;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    wsd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .space (space),
        .push  (push),
        .cmd   (push_cmd)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .space      (space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
`default_nettype wire
